@@ hw/rtl/scd_pkg.sv @@
// ----------------------------------------------------------------------------
// Seconds to calendar date: shared definitions
// Pipeline depth, epoch constant and the day/time split carried between
// the front end and the two back-end paths.
// ----------------------------------------------------------------------------
package scd_pkg;

   localparam int SPLIT_STAGES = 4;
   localparam int TAIL_STAGES  = 6;
   localparam int STAGE_COUNT  = SPLIT_STAGES + TAIL_STAGES;

   localparam int DAYS_WIDTH = 16;
   localparam int TOD_WIDTH  = 17;

   localparam logic [31:0] EPOCH_1980 = 32'd315532800;

   typedef struct packed {
      logic [DAYS_WIDTH-1:0] days;
      logic [TOD_WIDTH-1:0]  tod;
   } day_split_type;

endpackage

@@ hw/rtl/seconds_to_calendar_date.sv @@
// ----------------------------------------------------------------------------
// Seconds to calendar date: top level
// One transaction per cycle is taken while req_stall is low, set by the
// ten-stage multiply pipeline.
// Each stage holds while it is full and the one after it holds.
// Synchronous reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_second_of_minute,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [4:0]  rsp_hour_of_day,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month_number,
   output logic [11:0] rsp_year_number,
   output logic [2:0]  rsp_weekday_number,
   output logic [8:0]  rsp_day_of_year,
   output logic        rsp_before_epoch
);

   localparam int Stages = scd_pkg::STAGE_COUNT;
   localparam int Split  = scd_pkg::SPLIT_STAGES;

   logic [Stages-1:0] stage_en;
   logic [Stages-1:0] valid_in, valid_ff;
   logic [Stages-1:0] before_in, before_ff;
   scd_pkg::day_split_type split;
   logic [5:0]  second_raw, minute_raw;
   logic [4:0]  hour_raw, dom_raw;
   logic [3:0]  month_raw;
   logic [11:0] year_raw;
   logic [2:0]  weekday_raw;
   logic [8:0]  doy_raw;
   logic        out_before;

   always_comb begin
      stage_en[Stages-1] = !valid_ff[Stages-1] || !rsp_stall;
      for (int i = Stages - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
      valid_in[0]  = req_valid;
      before_in[0] = (req_epoch_seconds < scd_pkg::EPOCH_1980);
      for (int i = 1; i < Stages; i++) begin
         valid_in[i]  = valid_ff[i-1];
         before_in[i] = before_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < Stages; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (stage_en[i]) begin
            valid_ff[i] <= valid_in[i];
         end
         if (stage_en[i]) begin
            before_ff[i] <= before_in[i];
         end
      end
   end

   scd_day_split u_day_split (
      .clock         (clock),
      .stage_en      (stage_en[Split-1:0]),
      .epoch_seconds (req_epoch_seconds),
      .split         (split)
   );

   scd_clock_time u_clock_time (
      .clock            (clock),
      .stage_en         (stage_en[Stages-1:Split]),
      .tod              (split.tod),
      .hour_of_day      (hour_raw),
      .minute_of_hour   (minute_raw),
      .second_of_minute (second_raw)
   );

   scd_calendar u_calendar (
      .clock          (clock),
      .stage_en       (stage_en[Stages-1:Split]),
      .days           (split.days),
      .day_of_month   (dom_raw),
      .month_number   (month_raw),
      .year_number    (year_raw),
      .weekday_number (weekday_raw),
      .day_of_year    (doy_raw)
   );

   assign out_before = before_ff[Stages-1];

   assign req_stall            = !stage_en[0];
   assign rsp_valid            = valid_ff[Stages-1];
   assign rsp_before_epoch     = out_before;
   assign rsp_second_of_minute = out_before ? 6'd0 : second_raw;
   assign rsp_minute_of_hour   = out_before ? 6'd0 : minute_raw;
   assign rsp_hour_of_day      = out_before ? 5'd0 : hour_raw;
   assign rsp_day_of_month     = out_before ? 5'd0 : dom_raw;
   assign rsp_month_number     = out_before ? 4'd0 : month_raw;
   assign rsp_year_number      = out_before ? 12'd0 : year_raw;
   assign rsp_weekday_number   = out_before ? 3'd0 : weekday_raw;
   assign rsp_day_of_year      = out_before ? 9'd0 : doy_raw;

`ifndef SYNTH
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff) && rsp_stall)
      else $error("input stalled while the pipeline has a free stage");

   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_before_epoch |->
         rsp_second_of_minute < 6'd60 && rsp_minute_of_hour < 6'd60 &&
         rsp_hour_of_day < 5'd24)
      else $error("time of day out of range");

   a_date_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_before_epoch |->
         rsp_month_number != 4'd0 && rsp_month_number <= 4'd12 &&
         rsp_day_of_month != 5'd0 && rsp_day_of_year <= 9'd365 &&
         rsp_weekday_number != 3'd0 && rsp_year_number >= 12'd1980)
      else $error("calendar fields out of range");
`endif

endmodule

@@ hw/rtl/scd_day_split.sv @@
// ----------------------------------------------------------------------------
// Seconds to calendar date: day split
// Rebases the count to 1980 and splits it into whole days and the second
// within the day, using a reciprocal estimate and one correction step.
// ----------------------------------------------------------------------------
module scd_day_split (
   input  logic                              clock,
   input  logic [scd_pkg::SPLIT_STAGES-1:0]  stage_en,
   input  logic [31:0]                       epoch_seconds,
   output scd_pkg::day_split_type            split
);

   localparam logic [22:0] DayRecip = 23'd6362914;
   localparam logic [16:0] SecPerDay = 17'd86400;

   logic [31:0] t_s1_in, t_s1_ff;
   logic [31:0] t_s2_ff;
   logic [15:0] q_s2_in, q_s2_ff;
   logic [47:0] q_prod;
   logic [15:0] q_s3_ff;
   logic [17:0] r_s3_in, r_s3_ff;
   logic [32:0] back_prod;
   logic [31:0] diff;
   scd_pkg::day_split_type split_in, split_ff;

   always_comb begin
      t_s1_in   = epoch_seconds - scd_pkg::EPOCH_1980;
      q_prod    = 48'(t_s1_ff[31:7]) * 48'(DayRecip);
      q_s2_in   = q_prod[47:32];
      back_prod = 33'(q_s2_ff) * 33'(SecPerDay);
      diff      = t_s2_ff - back_prod[31:0];
      r_s3_in   = diff[17:0];
      if (r_s3_ff >= 18'(SecPerDay)) begin
         split_in.days = q_s3_ff + 16'd1;
         split_in.tod  = 17'(r_s3_ff - 18'(SecPerDay));
      end else begin
         split_in.days = q_s3_ff;
         split_in.tod  = r_s3_ff[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         t_s1_ff <= t_s1_in;
      end
      if (stage_en[1]) begin
         t_s2_ff <= t_s1_ff;
         q_s2_ff <= q_s2_in;
      end
      if (stage_en[2]) begin
         q_s3_ff <= q_s2_ff;
         r_s3_ff <= r_s3_in;
      end
      if (stage_en[3]) begin
         split_ff <= split_in;
      end
   end

   assign split = split_ff;

endmodule

@@ hw/rtl/scd_clock_time.sv @@
// ----------------------------------------------------------------------------
// Seconds to calendar date: time of day
// Splits the second within the day into hour, minute and second.
// ----------------------------------------------------------------------------
module scd_clock_time (
   input  logic                             clock,
   input  logic [scd_pkg::TAIL_STAGES-1:0]  stage_en,
   input  logic [scd_pkg::TOD_WIDTH-1:0]    tod,
   output logic [4:0]                       hour_of_day,
   output logic [5:0]                       minute_of_hour,
   output logic [5:0]                       second_of_minute
);

   localparam logic [14:0] HourRecip = 15'd18641;
   localparam logic [10:0] MinRecip  = 11'd1092;
   localparam logic [11:0] SecPerHour = 12'd3600;
   localparam logic [5:0]  SecPerMin  = 6'd60;

   logic [16:0] tod_s5_ff;
   logic [4:0]  h_s5_in, h_s5_ff;
   logic [31:0] h_prod;
   logic [4:0]  h_s6_ff;
   logic [12:0] hr_s6_in, hr_s6_ff;
   logic [16:0] h_back;
   logic [4:0]  hour_s7_in, hour_s7_ff;
   logic [11:0] rem_s7_in, rem_s7_ff;
   logic [22:0] m_prod;
   logic [5:0]  m_s8_in, m_s8_ff;
   logic [11:0] rem_s8_ff;
   logic [4:0]  hour_s8_ff;
   logic [11:0] m_back;
   logic [6:0]  ms_s9_in, ms_s9_ff;
   logic [5:0]  m_s9_ff;
   logic [4:0]  hour_s9_ff;
   logic [5:0]  min_s10_in, min_s10_ff;
   logic [5:0]  sec_s10_in, sec_s10_ff;
   logic [4:0]  hour_s10_ff;

   always_comb begin
      h_prod   = 32'(tod) * 32'(HourRecip);
      h_s5_in  = h_prod[30:26];
      h_back   = 17'(h_s5_ff) * 17'(SecPerHour);
      hr_s6_in = 13'(tod_s5_ff - h_back);
      if (hr_s6_ff >= 13'(SecPerHour)) begin
         hour_s7_in = h_s6_ff + 5'd1;
         rem_s7_in  = 12'(hr_s6_ff - 13'(SecPerHour));
      end else begin
         hour_s7_in = h_s6_ff;
         rem_s7_in  = hr_s6_ff[11:0];
      end
      m_prod   = 23'(rem_s7_ff) * 23'(MinRecip);
      m_s8_in  = m_prod[21:16];
      m_back   = 12'(m_s8_ff) * 12'(SecPerMin);
      ms_s9_in = 7'(rem_s8_ff - m_back);
      if (ms_s9_ff >= 7'(SecPerMin)) begin
         min_s10_in = m_s9_ff + 6'd1;
         sec_s10_in = 6'(ms_s9_ff - 7'(SecPerMin));
      end else begin
         min_s10_in = m_s9_ff;
         sec_s10_in = ms_s9_ff[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         tod_s5_ff <= tod;
         h_s5_ff   <= h_s5_in;
      end
      if (stage_en[1]) begin
         h_s6_ff  <= h_s5_ff;
         hr_s6_ff <= hr_s6_in;
      end
      if (stage_en[2]) begin
         hour_s7_ff <= hour_s7_in;
         rem_s7_ff  <= rem_s7_in;
      end
      if (stage_en[3]) begin
         m_s8_ff    <= m_s8_in;
         rem_s8_ff  <= rem_s7_ff;
         hour_s8_ff <= hour_s7_ff;
      end
      if (stage_en[4]) begin
         ms_s9_ff   <= ms_s9_in;
         m_s9_ff    <= m_s8_ff;
         hour_s9_ff <= hour_s8_ff;
      end
      if (stage_en[5]) begin
         min_s10_ff  <= min_s10_in;
         sec_s10_ff  <= sec_s10_in;
         hour_s10_ff <= hour_s9_ff;
      end
   end

   assign hour_of_day      = hour_s10_ff;
   assign minute_of_hour   = min_s10_ff;
   assign second_of_minute = sec_s10_ff;

endmodule

@@ hw/rtl/scd_calendar.sv @@
// ----------------------------------------------------------------------------
// Seconds to calendar date: calendar
// Turns the day count since 1980 into year, day of year, month, day of
// month and ISO weekday, with a leap year every fourth year.
// ----------------------------------------------------------------------------
module scd_calendar (
   input  logic                             clock,
   input  logic [scd_pkg::TAIL_STAGES-1:0]  stage_en,
   input  logic [scd_pkg::DAYS_WIDTH-1:0]   days,
   output logic [4:0]                       day_of_month,
   output logic [3:0]                       month_number,
   output logic [11:0]                      year_number,
   output logic [2:0]                       weekday_number,
   output logic [8:0]                       day_of_year
);

   localparam logic [15:0] CycleRecip = 16'd45933;
   localparam logic [15:0] WeekRecip  = 16'd37449;
   localparam logic [10:0] DaysPerCycle = 11'd1461;
   localparam logic [2:0]  DaysPerWeek  = 3'd7;
   localparam logic [11:0] BaseYear     = 12'd1980;
   localparam logic [10:0] Year1Start   = 11'd366;
   localparam logic [10:0] Year2Start   = 11'd731;
   localparam logic [10:0] Year3Start   = 11'd1096;
   localparam logic [8:0] MonthStart [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
      logic [8:0] base;
      base = MonthStart[mon];
      if (leap && mon >= 4'd2) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

   logic [15:0] days_s5_ff;
   logic [16:0] x_in, x_s5_ff;
   logic [31:0] c_prod;
   logic [32:0] w_prod;
   logic [4:0]  c_s5_in, c_s5_ff;
   logic [12:0] q7_s5_in, q7_s5_ff;
   logic [15:0] c_back;
   logic [16:0] w_back;
   logic [11:0] cp_s6_in, cp_s6_ff;
   logic [3:0]  w_s6_in, w_s6_ff;
   logic [4:0]  c_s6_ff;
   logic [10:0] cp_s7_in, cp_s7_ff;
   logic [4:0]  cyc_s7_in, cyc_s7_ff;
   logic [2:0]  wmod_s7_in, wmod_s7_ff;
   logic [1:0]  y_in;
   logic [10:0] y_base;
   logic [8:0]  doy_s8_in, doy_s8_ff;
   logic        leap_s8_ff;
   logic [6:0]  yoff_s8_ff;
   logic [2:0]  wd_s8_ff;
   logic [3:0]  mon_in;
   logic [4:0]  dom_s9_in, dom_s9_ff;
   logic [3:0]  mon_s9_ff;
   logic [8:0]  doy_s9_ff;
   logic [6:0]  yoff_s9_ff;
   logic [2:0]  wd_s9_ff;
   logic [4:0]  dom_s10_ff;
   logic [3:0]  mon_s10_ff;
   logic [11:0] year_s10_ff;
   logic [8:0]  doy_s10_ff;
   logic [2:0]  wd_s10_ff;

   always_comb begin
      x_in     = 17'(days) + 17'd1;
      c_prod   = 32'(days) * 32'(CycleRecip);
      c_s5_in  = c_prod[30:26];
      w_prod   = 33'(x_in) * 33'(WeekRecip);
      q7_s5_in = w_prod[30:18];

      c_back   = 16'(c_s5_ff) * 16'(DaysPerCycle);
      cp_s6_in = 12'(days_s5_ff - c_back);
      w_back   = 17'(q7_s5_ff) * 17'(DaysPerWeek);
      w_s6_in  = 4'(x_s5_ff - w_back);

      if (cp_s6_ff >= 12'(DaysPerCycle)) begin
         cp_s7_in  = 11'(cp_s6_ff - 12'(DaysPerCycle));
         cyc_s7_in = c_s6_ff + 5'd1;
      end else begin
         cp_s7_in  = cp_s6_ff[10:0];
         cyc_s7_in = c_s6_ff;
      end
      if (w_s6_ff >= 4'(DaysPerWeek)) begin
         wmod_s7_in = 3'(w_s6_ff - 4'(DaysPerWeek));
      end else begin
         wmod_s7_in = w_s6_ff[2:0];
      end

      priority if (cp_s7_ff >= Year3Start) begin
         y_in   = 2'd3;
         y_base = Year3Start;
      end else if (cp_s7_ff >= Year2Start) begin
         y_in   = 2'd2;
         y_base = Year2Start;
      end else if (cp_s7_ff >= Year1Start) begin
         y_in   = 2'd1;
         y_base = Year1Start;
      end else begin
         y_in   = 2'd0;
         y_base = 11'd0;
      end
      doy_s8_in = 9'(cp_s7_ff - y_base);

      mon_in = 4'd0;
      for (int m = 1; m < 12; m++) begin
         if (doy_s8_ff >= month_start(4'(m), leap_s8_ff)) begin
            mon_in = 4'(m);
         end
      end
      dom_s9_in = 5'(doy_s8_ff - month_start(mon_in, leap_s8_ff));
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         days_s5_ff <= days;
         x_s5_ff    <= x_in;
         c_s5_ff    <= c_s5_in;
         q7_s5_ff   <= q7_s5_in;
      end
      if (stage_en[1]) begin
         cp_s6_ff <= cp_s6_in;
         w_s6_ff  <= w_s6_in;
         c_s6_ff  <= c_s5_ff;
      end
      if (stage_en[2]) begin
         cp_s7_ff   <= cp_s7_in;
         cyc_s7_ff  <= cyc_s7_in;
         wmod_s7_ff <= wmod_s7_in;
      end
      if (stage_en[3]) begin
         doy_s8_ff  <= doy_s8_in;
         leap_s8_ff <= (y_in == 2'd0);
         yoff_s8_ff <= {cyc_s7_ff, y_in};
         wd_s8_ff   <= wmod_s7_ff + 3'd1;
      end
      if (stage_en[4]) begin
         dom_s9_ff  <= dom_s9_in;
         mon_s9_ff  <= mon_in;
         doy_s9_ff  <= doy_s8_ff;
         yoff_s9_ff <= yoff_s8_ff;
         wd_s9_ff   <= wd_s8_ff;
      end
      if (stage_en[5]) begin
         dom_s10_ff  <= dom_s9_ff + 5'd1;
         mon_s10_ff  <= mon_s9_ff + 4'd1;
         year_s10_ff <= 12'(yoff_s9_ff) + BaseYear;
         doy_s10_ff  <= doy_s9_ff;
         wd_s10_ff   <= wd_s9_ff;
      end
   end

   assign day_of_month   = dom_s10_ff;
   assign month_number   = mon_s10_ff;
   assign year_number    = year_s10_ff;
   assign weekday_number = wd_s10_ff;
   assign day_of_year    = doy_s10_ff;

endmodule
